### hdl/slew_limited_servo_pulse_mapper_assert.svh
// Assertion macros shared by the servo pulse mapper RTL.
`ifndef SLEW_LIMITED_SERVO_PULSE_MAPPER_ASSERT_SVH
`define SLEW_LIMITED_SERVO_PULSE_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
// check disabled while reset is asserted
`define SLSPM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
// check active at every edge, reset included
`define SLSPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define SLSPM_ASSERT(lbl, clk, rstn, prop)
`define SLSPM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hdl/slspm_pkg.sv
// Types and constants of the slew-limited servo pulse mapper.
package slspm_pkg;

    localparam int NUM_LANES   = 6;
    localparam int NUM_FINGERS = 5;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // channel order: thumb, index, middle, ring, little, wrist
    localparam logic [7:0] ANGLE_LO [NUM_LANES] =
        '{8'd2, 8'd70, 8'd85, 8'd100, 8'd100, 8'd0};
    // magnitude of angle_hi - angle_lo
    localparam logic [7:0] ANGLE_SPAN [NUM_LANES] =
        '{8'd28, 8'd70, 8'd75, 8'd70, 8'd110, 8'd180};
    // index finger runs from 70 down to 0
    localparam logic [NUM_LANES-1:0] SPAN_NEG = 6'b000010;

    localparam logic [6:0] FINGER_POS_INIT = 7'd0;
    localparam logic [6:0] WRIST_POS_INIT  = 7'd50;

    // x/100 = (x * 5243) >> 19, exact for x < 2^15
    localparam logic [12:0] RECIP_100 = 13'd5243;
    // y/45 = (y * 372828) >> 24, exact for y < 2^18 (x/180 = (x>>2)/45)
    localparam logic [18:0] RECIP_45  = 19'd372828;

    localparam logic [6:0]  FINGER_STEP_RST      = 7'd5;
    localparam logic [6:0]  WRIST_STEP_RST       = 7'd3;
    localparam logic [11:0] FINGER_PULSE_MIN_RST = 12'd544;
    localparam logic [11:0] FINGER_PULSE_MAX_RST = 12'd2400;
    localparam logic [11:0] WRIST_PULSE_MIN_RST  = 12'd500;
    localparam logic [11:0] WRIST_PULSE_MAX_RST  = 12'd2500;

    typedef enum logic [2:0] {
        CFG_FINGER_STEP      = 3'd0,
        CFG_WRIST_STEP       = 3'd1,
        CFG_FINGER_PULSE_MIN = 3'd2,
        CFG_FINGER_PULSE_MAX = 3'd3,
        CFG_WRIST_PULSE_MIN  = 3'd4,
        CFG_WRIST_PULSE_MAX  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0]  step;
        logic [11:0] pmin;
        logic [11:0] pmax;
        logic [7:0]  angle_lo;
        logic [7:0]  span;
        logic        span_neg;
        logic [6:0]  pos_init;
    } lane_cfg_t;

endpackage

### hdl/slew_limited_servo_pulse_mapper.sv
// Six servo channels (five fingers and a wrist) run in parallel lanes; each beat
// is one control frame. A lane clamps its target to 100 %, slews its stored
// position by at most the finger or wrist step, then maps position to angle and
// angle to pulse width through a four-stage register pipeline (two products and
// two reciprocal multiplies for the divisions by 100 and 180). A new frame is
// taken only once the previous one has passed the lane pipeline and been loaded
// into the output register, which lets a new frame enter while the previous
// result still waits. Config writes are taken at any time but must only happen
// while the block is idle.
`include "slew_limited_servo_pulse_mapper_assert.svh"

module slew_limited_servo_pulse_mapper
    import slspm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_target_thumb,
    input  logic [7:0]  s_target_index,
    input  logic [7:0]  s_target_middle,
    input  logic [7:0]  s_target_ring,
    input  logic [7:0]  s_target_little,
    input  logic [7:0]  s_target_wrist,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pulse_thumb,
    output logic [11:0] m_pulse_index,
    output logic [11:0] m_pulse_middle,
    output logic [11:0] m_pulse_ring,
    output logic [11:0] m_pulse_little,
    output logic [11:0] m_pulse_wrist,
    output logic [6:0]  m_pos_thumb,
    output logic [6:0]  m_pos_index,
    output logic [6:0]  m_pos_middle,
    output logic [6:0]  m_pos_ring,
    output logic [6:0]  m_pos_little,
    output logic [6:0]  m_pos_wrist
);

    logic [6:0]  finger_step_reg;
    logic [6:0]  wrist_step_reg;
    logic [11:0] finger_pmin_reg;
    logic [11:0] finger_pmax_reg;
    logic [11:0] wrist_pmin_reg;
    logic [11:0] wrist_pmax_reg;

    state_t      state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        load;
    logic        out_free;

    logic [7:0]  target     [NUM_LANES];
    lane_cfg_t   lane_cfg   [NUM_LANES];
    logic [11:0] lane_pulse [NUM_LANES];
    logic [6:0]  lane_pos   [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_step_reg <= FINGER_STEP_RST;
            wrist_step_reg  <= WRIST_STEP_RST;
            finger_pmin_reg <= FINGER_PULSE_MIN_RST;
            finger_pmax_reg <= FINGER_PULSE_MAX_RST;
            wrist_pmin_reg  <= WRIST_PULSE_MIN_RST;
            wrist_pmax_reg  <= WRIST_PULSE_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FINGER_STEP:      finger_step_reg <= cfg_wdata[6:0];
                CFG_WRIST_STEP:       wrist_step_reg  <= cfg_wdata[6:0];
                CFG_FINGER_PULSE_MIN: finger_pmin_reg <= cfg_wdata;
                CFG_FINGER_PULSE_MAX: finger_pmax_reg <= cfg_wdata;
                CFG_WRIST_PULSE_MIN:  wrist_pmin_reg  <= cfg_wdata;
                CFG_WRIST_PULSE_MAX:  wrist_pmax_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = 2'd0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                // four pipeline stages after the position update
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_DONE;
                    cnt_next   = 2'd0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        load    = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_DONE: load    = out_free;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    assign target[0] = s_target_thumb;
    assign target[1] = s_target_index;
    assign target[2] = s_target_middle;
    assign target[3] = s_target_ring;
    assign target[4] = s_target_little;
    assign target[5] = s_target_wrist;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        if (g < NUM_FINGERS) begin : g_finger
            assign lane_cfg[g].step     = finger_step_reg;
            assign lane_cfg[g].pmin     = finger_pmin_reg;
            assign lane_cfg[g].pmax     = finger_pmax_reg;
            assign lane_cfg[g].pos_init = FINGER_POS_INIT;
        end else begin : g_wrist
            assign lane_cfg[g].step     = wrist_step_reg;
            assign lane_cfg[g].pmin     = wrist_pmin_reg;
            assign lane_cfg[g].pmax     = wrist_pmax_reg;
            assign lane_cfg[g].pos_init = WRIST_POS_INIT;
        end
        assign lane_cfg[g].angle_lo = ANGLE_LO[g];
        assign lane_cfg[g].span     = ANGLE_SPAN[g];
        assign lane_cfg[g].span_neg = SPAN_NEG[g];

        slspm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (lane_cfg[g]),
            .accept  (accept),
            .target  (target[g]),
            .pos     (lane_pos[g]),
            .pulse   (lane_pulse[g])
        );
    end

    slspm_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .free           (out_free),
        .lane_pulse     (lane_pulse),
        .lane_pos       (lane_pos),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pulse_thumb  (m_pulse_thumb),
        .m_pulse_index  (m_pulse_index),
        .m_pulse_middle (m_pulse_middle),
        .m_pulse_ring   (m_pulse_ring),
        .m_pulse_little (m_pulse_little),
        .m_pulse_wrist  (m_pulse_wrist),
        .m_pos_thumb    (m_pos_thumb),
        .m_pos_index    (m_pos_index),
        .m_pos_middle   (m_pos_middle),
        .m_pos_ring     (m_pos_ring),
        .m_pos_little   (m_pos_little),
        .m_pos_wrist    (m_pos_wrist)
    );

    `SLSPM_ASSERT(a_one_in_flight, aclk, aresetn, accept |=> !s_ready)
    `SLSPM_ASSERT(a_lane_latency, aclk, aresetn, accept |-> ##5 (state_reg == ST_DONE))
    `SLSPM_ASSERT(a_load_from_done, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == ST_DONE))

endmodule

### hdl/slspm_lane.sv
// One channel lane: clamp, slew, position-to-angle and angle-to-pulse pipeline.
`include "slew_limited_servo_pulse_mapper_assert.svh"

module slspm_lane
    import slspm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_cfg_t   cfg,
    input  logic        accept,
    input  logic [7:0]  target,
    output logic [6:0]  pos,
    output logic [11:0] pulse
);

    logic [6:0]  tgt;
    logic [6:0]  pos_reg, pos_next;
    logic [14:0] prod1_reg, prod1_next;
    logic [27:0] q100_full;
    logic [8:0]  q100;
    logic [8:0]  angle_sum;
    logic [7:0]  angle_reg;
    logic [11:0] diff;
    logic [19:0] prod2_reg, prod2_next;
    logic [36:0] q180_full;
    logic [12:0] q180;
    logic [12:0] pulse_sum;
    logic [11:0] pulse_reg, pulse_next;

    assign tgt = (target > {1'b0, PCT_FULL}) ? PCT_FULL : target[6:0];

    always_comb begin
        if (tgt > pos_reg && (tgt - pos_reg) > cfg.step) begin
            pos_next = pos_reg + cfg.step;
        end else if (pos_reg > tgt && (pos_reg - tgt) > cfg.step) begin
            pos_next = pos_reg - cfg.step;
        end else begin
            pos_next = tgt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= cfg.pos_init;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    // free-running datapath; pos_reg only moves on a beat
    assign prod1_next = {8'd0, pos_reg} * {7'd0, cfg.span};

    assign q100_full = {13'd0, prod1_reg} * {15'd0, RECIP_100};
    assign q100      = q100_full[27:19];
    assign angle_sum = cfg.span_neg ? ({1'b0, cfg.angle_lo} - q100)
                                    : ({1'b0, cfg.angle_lo} + q100);

    assign diff       = cfg.pmax - cfg.pmin;
    assign prod2_next = {12'd0, angle_reg} * {8'd0, diff};

    assign q180_full = {19'd0, prod2_reg[19:2]} * {18'd0, RECIP_45};
    assign q180      = q180_full[36:24];
    assign pulse_sum = {1'b0, cfg.pmin} + q180;

    always_comb begin
        if (cfg.pmax < cfg.pmin) begin
            pulse_next = cfg.pmax;
        end else if (pulse_sum > {1'b0, cfg.pmax}) begin
            pulse_next = cfg.pmax;
        end else begin
            pulse_next = pulse_sum[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod1_reg <= prod1_next;
        angle_reg <= angle_sum[7:0];
        prod2_reg <= prod2_next;
        pulse_reg <= pulse_next;
    end

    assign pos   = pos_reg;
    assign pulse = pulse_reg;

    `SLSPM_ASSERT(a_pos_in_range, aclk, aresetn, pos_reg <= PCT_FULL)

endmodule

### hdl/slspm_merge.sv
// Output register that gathers all lane results into one result beat.
`include "slew_limited_servo_pulse_mapper_assert.svh"

module slspm_merge
    import slspm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    output logic        free,
    input  logic [11:0] lane_pulse [NUM_LANES],
    input  logic [6:0]  lane_pos   [NUM_LANES],
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pulse_thumb,
    output logic [11:0] m_pulse_index,
    output logic [11:0] m_pulse_middle,
    output logic [11:0] m_pulse_ring,
    output logic [11:0] m_pulse_little,
    output logic [11:0] m_pulse_wrist,
    output logic [6:0]  m_pos_thumb,
    output logic [6:0]  m_pos_index,
    output logic [6:0]  m_pos_middle,
    output logic [6:0]  m_pos_ring,
    output logic [6:0]  m_pos_little,
    output logic [6:0]  m_pos_wrist
);

    logic        valid_reg;
    logic [11:0] pulse_reg [NUM_LANES];
    logic [6:0]  pos_reg   [NUM_LANES];

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pulse_reg <= lane_pulse;
            pos_reg   <= lane_pos;
        end
    end

    assign m_valid        = valid_reg;
    assign m_pulse_thumb  = pulse_reg[0];
    assign m_pulse_index  = pulse_reg[1];
    assign m_pulse_middle = pulse_reg[2];
    assign m_pulse_ring   = pulse_reg[3];
    assign m_pulse_little = pulse_reg[4];
    assign m_pulse_wrist  = pulse_reg[5];
    assign m_pos_thumb    = pos_reg[0];
    assign m_pos_index    = pos_reg[1];
    assign m_pos_middle   = pos_reg[2];
    assign m_pos_ring     = pos_reg[3];
    assign m_pos_little   = pos_reg[4];
    assign m_pos_wrist    = pos_reg[5];

    `SLSPM_ASSERT(a_no_overwrite, aclk, aresetn, load |-> (!valid_reg || m_ready))
    `SLSPM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !valid_reg)

endmodule
